### hdl/boi_pkg.sv
// Shared types for the bicycle odometry integrator: payloads and unit handshakes.
package boi_pkg;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWheelbase    = 3'd0,
    CfgThreshold    = 3'd1,
    CfgStartX       = 3'd2,
    CfgStartY       = 3'd3,
    CfgStartHeading = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] speed;
    logic signed [15:0] steer_angle;
    logic [19:0]        dt_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [15:0] vel_term_a;
    logic signed [15:0] vel_term_b;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] yaw_term_a;
    logic signed [15:0] yaw_term_b;
    logic               reset_ack;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] sin_v;
    logic signed [33:0] cos_v;
  } cor_res_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [25:0] den;
    logic [5:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
  } div_res_t;

endpackage

### hdl/boi_cordic.sv
// Iterative CORDIC rotator giving sine and cosine of a binary angle, one step per cycle.
module boi_cordic #(
  parameter int STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  boi_pkg::cor_req_t req_i,
  output boi_pkg::cor_res_t res_o
);

  localparam logic [4:0] LastStep = 5'(STEPS - 1);
  localparam logic signed [33:0] StartX = 34'sd652032874;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  logic signed [33:0] x_q, y_q, z_q;
  logic [4:0]         cnt_q;
  logic               busy_q, done_q, neg_q;

  logic               fold;
  logic [31:0]        folded;
  logic signed [33:0] xs, ys, at;

  // Angles in the second and third quadrant are turned by half a turn first.
  assign fold   = (req_i.angle[31:30] == 2'b01) || (req_i.angle[31:30] == 2'b10);
  assign folded = fold ? {~req_i.angle[31], req_i.angle[30:0]} : req_i.angle;
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign at     = $signed({2'b00, atan_entry(cnt_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        x_q    <= StartX;
        y_q    <= '0;
        z_q    <= 34'($signed(folded));
        neg_q  <= fold;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done  = done_q;
  assign res_o.sin_v = neg_q ? -y_q : y_q;
  assign res_o.cos_v = neg_q ? -x_q : x_q;

endmodule

### hdl/boi_divider.sv
// Restoring shift-subtract divider of unsigned magnitudes, one quotient bit per cycle.
module boi_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  boi_pkg::div_req_t req_i,
  output boi_pkg::div_res_t res_o
);

  logic [63:0] num_q;
  logic [25:0] rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;

  logic [26:0] trial;
  logic [27:0] diff;
  logic        ge;

  assign trial = {rem_q, num_q[63]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = !diff[27];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
        cnt_q  <= req_i.iters;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[25:0] : trial[25:0];
        num_q <= {num_q[62:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = num_q[47:0];

endmodule

### hdl/bicycle_odometry_integrator.sv
// Top level of the bicycle-model dead-reckoning pose integrator.
//
// Usage: motion samples arrive on the input channel (in_valid_i / in_stall_o) as
// speed, steering angle and elapsed time; each transaction yields exactly one result
// transaction on the output channel (out_valid_o / out_stall_i) with the new pose,
// the rotated velocity terms and the yaw rate. The configuration channel (cfg_valid_i
// / cfg_ready_o) is always ready and should only be written while the block is idle.
// The next sample can be taken in the cycle after the result is loaded. The sequence
// uses the bit-serial divider (30 iterations for the yaw rate, 48 for each exact arc
// step) and the single CORDIC rotator, which runs three or four times per sample.
// The travel distance uses a reciprocal multiplication with one correction step. A
// pose reset transaction goes from acceptance straight to the output state.
// Only one sample is in flight; in_stall_o is high from acceptance until its result
// has been loaded into the output register. A result waiting under out_stall_i does
// not block the next sample, but that sample's result waits for the register to free.
// After reset the pose is zero; the block does not store the start values.
// Writes to the start indexes are accepted but never reach the pose, since the
// block resets the pose only through reset itself or a pose reset transaction.
module bicycle_odometry_integrator #(
  parameter int CORDIC_STEPS = 16,
  parameter int MAX_DT_US    = 1000000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  boi_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output boi_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [boi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam logic [19:0]        MaxDt     = 20'(MAX_DT_US);
  localparam logic signed [34:0] SteerGain = 35'sd683565276;
  localparam logic signed [34:0] HeadGain  = 35'sd2799883;
  // Distance in Q16.16 is 4 * |speed * dt| / 15625; the reciprocal is 2^44 / 15625
  // rounded down, applied to the product shifted right by 10.
  localparam logic signed [34:0] DistRecip = 35'sd1125899906;
  localparam logic signed [34:0] DistDivS  = 35'sd15625;
  localparam logic [36:0]        DistDiv   = 37'd15625;

  typedef enum logic [5:0] {
    S_IDLE, S_STEER, S_ANG, S_ACOR, S_VSS, S_YSTART, S_YDIV, S_WDT, S_KHI, S_KLO,
    S_DTH, S_VDT, S_DSTART, S_DEST, S_DCOR, S_MSTART, S_MCOR, S_MX, S_MY, S_MYW,
    S_E0S, S_E0W, S_E1S, S_E1W, S_EMX, S_EDXS, S_EDXW, S_EMY, S_EDYS, S_EDYW,
    S_UPD, S_FSTART, S_FWAIT, S_F1, S_F2, S_F3, S_F4, S_F5, S_OUT
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
    logic signed [15:0] r;
    if (v > 41'sd32767) r = 16'sh7FFF;
    else if (v < -41'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -41'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  state_e state_q;

  // Configuration.
  logic [15:0] wheelbase_q;
  logic [14:0] thresh_q;

  // Sample and working registers.
  logic               out_valid_q;
  boi_pkg::out_item_t out_q;
  logic signed [15:0] v_q, st_q, w_q;
  logic [19:0]        dt_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [31:0]        heading_q, h1_q, mid_q;
  logic signed [60:0] prod_q, acc_q;
  logic [16:0]        plo_q;
  logic               dsign_q, ack_q;
  logic signed [25:0] dist_q;
  logic [34:0]        pabs_q;
  logic [23:0]        qest_q;
  logic signed [39:0] dx_q, dy_q;
  logic signed [33:0] s0_q, c0_q;
  logic signed [15:0] fa_q, fb_q, ya_q, yb_q;

  logic signed [25:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [60:0] prod_abs, dsum;
  logic signed [40:0] qext, qsig;
  logic [15:0]        wb_eff, w_abs;
  logic [36:0]        drem;
  logic [25:0]        dq;

  boi_pkg::cor_req_t cor_req;
  boi_pkg::cor_res_t cor_res;
  boi_pkg::div_req_t div_req;
  boi_pkg::div_res_t div_res;

  boi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .res_o  (cor_res)
  );

  boi_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // A zero wheelbase is treated as one unit.
  assign wb_eff   = (wheelbase_q == 16'd0) ? 16'd1 : wheelbase_q;
  assign w_abs    = w_q[15] ? 16'(-w_q) : 16'(w_q);
  assign prod_abs = prod_q[60] ? -prod_q : prod_q;
  assign dsum     = acc_q + prod_q;

  // Divider magnitudes are re-signed so that quotients truncate toward zero.
  assign qext = $signed({1'b0, div_res.quot[39:0]});
  assign qsig = dsign_q ? -qext : qext;

  // The reciprocal estimate is at most one below the true distance quotient.
  assign drem = {pabs_q, 2'b00} - prod_q[36:0];
  assign dq   = {2'b00, qest_q} + {25'd0, (drem >= DistDiv)};

  // The shared multiplier: operands are chosen by the sequencer state.
  always_comb begin
    mul_a = 26'(v_q);
    mul_b = 35'(cor_res.sin_v);
    unique case (state_q)
      S_STEER: begin
        mul_a = 26'(st_q);
        mul_b = SteerGain;
      end
      S_WDT: begin
        mul_a = 26'(w_q);
        mul_b = 35'($signed({1'b0, dt_q}));
      end
      S_KHI: begin
        mul_a = 26'($signed(prod_q[36:17]));
        mul_b = HeadGain;
      end
      S_KLO: begin
        mul_a = 26'($signed({1'b0, plo_q}));
        mul_b = HeadGain;
      end
      S_VDT: mul_b = 35'($signed({1'b0, dt_q}));
      S_DSTART: begin
        mul_a = {1'b0, prod_abs[34:10]};
        mul_b = DistRecip;
      end
      S_DEST: begin
        mul_a = {2'b00, prod_q[55:32]};
        mul_b = DistDivS;
      end
      S_MX: begin
        mul_a = dist_q;
        mul_b = 35'(cor_res.cos_v);
      end
      S_MY: mul_a = dist_q;
      S_EMX: mul_b = 35'(cor_res.sin_v) - 35'(s0_q);
      S_EMY: mul_b = 35'(cor_res.cos_v) - 35'(c0_q);
      S_F2: mul_b = 35'(cor_res.cos_v);
      S_F3: mul_a = 26'(w_q);
      S_F4: begin
        mul_a = 26'(w_q);
        mul_b = 35'(cor_res.cos_v);
      end
      default: ;
    endcase
  end

  // Start requests to the CORDIC and the divider.
  always_comb begin
    cor_req.start = 1'b0;
    cor_req.angle = h1_q;
    div_req.start = 1'b0;
    div_req.num   = {prod_abs[47:0], 16'd0};
    div_req.den   = {w_abs, 10'd0};
    div_req.iters = 6'd48;
    unique case (state_q)
      S_ANG: begin
        cor_req.start = 1'b1;
        cor_req.angle = prod_q[44:13];
      end
      S_MSTART: begin
        cor_req.start = 1'b1;
        cor_req.angle = mid_q;
      end
      S_E0S: begin
        cor_req.start = 1'b1;
        cor_req.angle = heading_q;
      end
      S_E1S, S_FSTART: cor_req.start = 1'b1;
      S_YSTART: begin
        // Dividing by wheelbase * 2^18 is the same as flooring by 2^18 first.
        div_req.start = 1'b1;
        div_req.num   = {prod_abs[47:18], 34'd0};
        div_req.den   = {10'd0, wb_eff};
        div_req.iters = 6'd30;
      end
      S_EDXS, S_EDYS: div_req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q <= 16'd717;
      thresh_q    <= 15'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        boi_pkg::CfgWheelbase: wheelbase_q <= cfg_data_i[15:0];
        boi_pkg::CfgThreshold: thresh_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer, pose state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      heading_q   <= '0;
    end else begin
      prod_q <= mul_a * mul_b;
      // In S_OUT the output register is handled by the state itself.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            v_q  <= in_data_i.speed;
            st_q <= in_data_i.steer_angle;
            dt_q <= (in_data_i.dt_us > MaxDt) ? 20'd0 : in_data_i.dt_us;
            if (in_data_i.operation) begin
              // Pose reset transaction: zero pose, all terms zero.
              pose_x_q  <= '0;
              pose_y_q  <= '0;
              heading_q <= '0;
              w_q       <= '0;
              fa_q      <= '0;
              fb_q      <= '0;
              ya_q      <= '0;
              yb_q      <= '0;
              ack_q     <= 1'b1;
              state_q   <= S_OUT;
            end else begin
              ack_q   <= 1'b0;
              state_q <= S_STEER;
            end
          end
        end
        S_STEER: state_q <= S_ANG;
        S_ANG:   state_q <= S_ACOR;
        S_ACOR:  if (cor_res.done) state_q <= S_VSS;
        S_VSS:   state_q <= S_YSTART;
        S_YSTART: begin
          dsign_q <= prod_q[60];
          state_q <= S_YDIV;
        end
        S_YDIV: begin
          if (div_res.done) begin
            w_q     <= sat16(qsig);
            state_q <= S_WDT;
          end
        end
        S_WDT: state_q <= S_KHI;
        S_KHI: begin
          plo_q   <= prod_q[16:0];
          state_q <= S_KLO;
        end
        S_KLO: begin
          acc_q   <= prod_q <<< 17;
          state_q <= S_DTH;
        end
        S_DTH: begin
          h1_q  <= heading_q + dsum[55:24];
          mid_q <= heading_q + dsum[56:25];
          // Zero yaw rate always takes the midpoint path.
          if ((w_q == 16'sd0) || (w_abs < {1'b0, thresh_q})) state_q <= S_VDT;
          else state_q <= S_E0S;
        end
        S_VDT: state_q <= S_DSTART;
        S_DSTART: begin
          dsign_q <= prod_q[60];
          pabs_q  <= prod_abs[34:0];
          state_q <= S_DEST;
        end
        S_DEST: begin
          qest_q  <= prod_q[55:32];
          state_q <= S_DCOR;
        end
        S_DCOR: begin
          dist_q  <= dsign_q ? -dq : dq;
          state_q <= S_MSTART;
        end
        S_MSTART: state_q <= S_MCOR;
        S_MCOR:   if (cor_res.done) state_q <= S_MX;
        S_MX:     state_q <= S_MY;
        S_MY: begin
          dx_q    <= 40'($signed(prod_q[60:30]));
          state_q <= S_MYW;
        end
        S_MYW: begin
          dy_q    <= 40'($signed(prod_q[60:30]));
          state_q <= S_UPD;
        end
        S_E0S: state_q <= S_E0W;
        S_E0W: begin
          if (cor_res.done) begin
            s0_q    <= cor_res.sin_v;
            c0_q    <= cor_res.cos_v;
            state_q <= S_E1S;
          end
        end
        S_E1S: state_q <= S_E1W;
        S_E1W: if (cor_res.done) state_q <= S_EMX;
        S_EMX: state_q <= S_EDXS;
        S_EDXS: begin
          dsign_q <= prod_q[60] ^ w_q[15];
          state_q <= S_EDXW;
        end
        S_EDXW: begin
          if (div_res.done) begin
            dx_q    <= qsig[39:0];
            state_q <= S_EMY;
          end
        end
        S_EMY: state_q <= S_EDYS;
        S_EDYS: begin
          // The lateral step carries an extra negation.
          dsign_q <= ~(prod_q[60] ^ w_q[15]);
          state_q <= S_EDYW;
        end
        S_EDYW: begin
          if (div_res.done) begin
            dy_q    <= qsig[39:0];
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          pose_x_q  <= sat32(41'(pose_x_q) + 41'(dx_q));
          pose_y_q  <= sat32(41'(pose_y_q) + 41'(dy_q));
          heading_q <= h1_q;
          state_q   <= S_FSTART;
        end
        S_FSTART: state_q <= S_FWAIT;
        S_FWAIT:  if (cor_res.done) state_q <= S_F1;
        S_F1:     state_q <= S_F2;
        S_F2: begin
          fa_q    <= sat16(41'($signed(prod_q[60:30])));
          state_q <= S_F3;
        end
        S_F3: begin
          fb_q    <= sat16(41'($signed(prod_q[60:30])));
          state_q <= S_F4;
        end
        S_F4: begin
          ya_q    <= sat16(41'($signed(prod_q[60:30])));
          state_q <= S_F5;
        end
        S_F5: begin
          yb_q    <= sat16(41'($signed(prod_q[60:30])));
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.pos_x      <= pose_x_q;
            out_q.pos_y      <= pose_y_q;
            out_q.heading    <= heading_q;
            out_q.vel_term_a <= fa_q;
            out_q.vel_term_b <= fb_q;
            out_q.yaw_rate   <= w_q;
            out_q.yaw_term_a <= ya_q;
            out_q.yaw_term_b <= yb_q;
            out_q.reset_ack  <= ack_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/tb_bicycle_odometry_integrator.sv
// Self-checking testbench for the bicycle odometry integrator, with its own pose predictor.
`timescale 1ns / 1ps

module tb_bicycle_odometry_integrator;

  localparam int  CordicSteps = 16;
  localparam int  MaxDtUs     = 1000000;
  // Settle time after the last result before idling the block for a register write.
  localparam int  SettleCycles = 300;
  // Arctangent table in binary angle units, one entry per CORDIC rotation.
  localparam longint AtanTab [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct {
    boi_pkg::in_item_t  item;
    bit                 typed;
    boi_pkg::out_item_t res;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  boi_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  boi_pkg::out_item_t out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  // Predictor copy of the configuration and the pose.
  logic [15:0]        wheelbase_q;
  logic [14:0]        threshold_q;
  logic signed [31:0] pose_x_q;
  logic signed [31:0] pose_y_q;
  logic [31:0]        pose_h_q;

  boi_pkg::out_item_t pose_results_q [$];
  int        fail_count;
  int        mismatch_count;
  bit        steady;      // when set, neither side inserts idle cycles
  int        stall_left;

  bicycle_odometry_integrator #(
    .CORDIC_STEPS(CordicSteps),
    .MAX_DT_US   (MaxDtUs)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine of a binary angle in Q2.30: fold by half a turn, then rotate.
  function automatic void rotate_unit(input logic [31:0] ang, output longint s,
                                      output longint c);
    bit     neg;
    longint x, y, z, nx;
    neg = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (neg) ang = ang - 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanTab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanTab[i];
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  // Advances the predicted pose by one transaction and returns the expected result.
  function automatic boi_pkg::out_item_t advance_pose(boi_pkg::in_item_t it);
    longint    v, st, dt, wb, ss, cs, w, aw, dth, dx, dy, travel;
    longint    sm, cm, s0, c0, s1, c1, sh, ch;
    logic [31:0] ang, h1, mid;
    boi_pkg::out_item_t r;
    r = '0;
    if (it.operation) begin
      pose_x_q = '0;
      pose_y_q = '0;
      pose_h_q = '0;
      r.reset_ack = 1'b1;
      return r;
    end
    v  = longint'(it.speed);
    st = longint'(it.steer_angle);
    dt = longint'({1'b0, it.dt_us});
    if (dt > MaxDtUs) dt = 0;
    wb = (wheelbase_q == 16'd0) ? 1 : longint'({1'b0, wheelbase_q});

    ang = 32'((st * 683565276) >>> 13);
    rotate_unit(ang, ss, cs);
    w  = clamp((v * ss) / (wb <<< 18), -32768, 32767);
    aw = w < 0 ? -w : w;
    dth = (w * dt * 2799883) >>> 24;
    h1  = pose_h_q + 32'(dth);

    if (w == 0 || aw < longint'({1'b0, threshold_q})) begin
      // Midpoint step: travel along the heading halfway through the turn.
      travel = (v * dt * 256) / 1000000;
      mid    = pose_h_q + 32'(dth >>> 1);
      rotate_unit(mid, sm, cm);
      dx = (travel * cm) >>> 30;
      dy = (travel * sm) >>> 30;
    end else begin
      // Exact arc: chord from the start heading to the end heading.
      rotate_unit(pose_h_q, s0, c0);
      rotate_unit(h1, s1, c1);
      dx = (v * (s1 - s0)) / (w * 1024);
      dy = -((v * (c1 - c0)) / (w * 1024));
    end

    pose_x_q = 32'(clamp(longint'(pose_x_q) + dx, -64'sd2147483648, 64'sd2147483647));
    pose_y_q = 32'(clamp(longint'(pose_y_q) + dy, -64'sd2147483648, 64'sd2147483647));
    pose_h_q = h1;

    rotate_unit(pose_h_q, sh, ch);
    r.pos_x      = pose_x_q;
    r.pos_y      = pose_y_q;
    r.heading    = pose_h_q;
    r.vel_term_a = 16'(clamp((v * sh) >>> 30, -32768, 32767));
    r.vel_term_b = 16'(clamp((v * ch) >>> 30, -32768, 32767));
    r.yaw_rate   = 16'(w);
    r.yaw_term_a = 16'(clamp((w * sh) >>> 30, -32768, 32767));
    r.yaw_term_b = 16'(clamp((w * ch) >>> 30, -32768, 32767));
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random motion sample. A cruise sample drives nearly straight at full speed for
  // close to a second so that the position runs into saturation.
  function automatic boi_pkg::in_item_t random_sample(bit cruise, bit backwards);
    boi_pkg::in_item_t it;
    int       r;
    it = '0;
    if (cruise) begin
      it.speed       = 16'($urandom_range(30000, 32767));
      if (backwards) it.speed = -it.speed;
      it.steer_angle = 16'($signed($urandom_range(0, 8)) - 4);
      it.dt_us       = 20'($urandom_range(900000, 1000000));
      return it;
    end
    it.operation = ($urandom_range(0, 99) < 4);
    r = $urandom_range(0, 2);
    it.speed = (r == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
    r = $urandom_range(0, 2);
    it.steer_angle = (r == 0) ? 16'($urandom) :
                     (r == 1) ? 16'($signed($urandom_range(0, 4000)) - 2000) : 16'd0;
    r = $urandom_range(0, 9);
    it.dt_us = (r < 4) ? 20'($urandom_range(0, 50000)) :
               (r < 8) ? 20'($urandom_range(0, MaxDtUs)) : 20'($urandom);
    return it;
  endfunction

  // One input transaction; returns at the falling edge after acceptance with valid high.
  task automatic send_sample(boi_pkg::in_item_t it, bit typed,
                             boi_pkg::out_item_t typed_res);
    boi_pkg::out_item_t pred;
    int        gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pred = advance_pose(it);
    pose_results_q.push_back(typed ? typed_res : pred);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Register write; valid stays high so that back-to-back writes need no second assignment.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    case (idx)
      boi_pkg::CfgWheelbase: wheelbase_q = data[15:0];
      boi_pkg::CfgThreshold: threshold_q = data[14:0];
      default: ;  // start indexes are not stored by the block and never reach the pose
    endcase
  endtask

  // Let every outstanding transaction drain and the block fall idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pose_results_q.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic reconfigure(logic [15:0] wb, logic [14:0] thr);
    drain();
    write_reg(boi_pkg::CfgWheelbase, {16'($urandom), wb});
    write_reg(boi_pkg::CfgThreshold, {17'($urandom), thr});
    write_reg(boi_pkg::CfgStartX, $urandom);
    write_reg(boi_pkg::CfgStartY, $urandom);
    write_reg(boi_pkg::CfgStartHeading, $urandom);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Output side: random back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 99) < 60) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 2);
    end
  end

  // Every result transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pose_results_q.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result transaction with nothing expected: %h", out_data_o);
      end else if (out_data_o !== pose_results_q[0]) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Mismatch: expected %h, got %h", pose_results_q[0], out_data_o);
        void'(pose_results_q.pop_front());
      end else begin
        void'(pose_results_q.pop_front());
      end
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    boi_pkg::out_item_t zero_res, ack_res;
    logic [2:0] spare_idx;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    fail_count     = 0;
    mismatch_count = 0;
    stall_left     = 0;
    steady         = 1'b0;
    wheelbase_q = 16'd717;
    threshold_q = 15'd4096;
    pose_x_q = '0;
    pose_y_q = '0;
    pose_h_q = '0;
    zero_res = '0;
    ack_res  = '0;
    ack_res.reset_ack = 1'b1;

    // Directed rows: operation, speed, steering, dt. Rows with zero speed or a pose
    // reset have an obvious result; everything else goes through the predictor.
    dir_tab = '{
      '{'{1'b1, 16'sh7fff, 16'sh8000, 20'hfffff}, 1'b1, ack_res},
      '{'{1'b0, 16'sd0,    16'sd0,    20'd0},     1'b1, zero_res},
      '{'{1'b0, 16'sd0,    16'sh7fff, 20'd1000000}, 1'b1, zero_res},
      '{'{1'b0, 16'sh7fff, 16'sd0,    20'd1000000}, 1'b0, zero_res},
      '{'{1'b0, 16'sh8000, 16'sd0,    20'd1000000}, 1'b0, zero_res},
      '{'{1'b0, 16'sh7fff, 16'sh7fff, 20'd1000000}, 1'b0, zero_res},
      '{'{1'b0, 16'sh8000, 16'sh8000, 20'd1000000}, 1'b0, zero_res},
      '{'{1'b0, 16'sh7fff, 16'sh8000, 20'd1000001}, 1'b0, zero_res},
      '{'{1'b0, 16'sd12800, 16'sd2000, 20'hfffff},  1'b0, zero_res},
      '{'{1'b0, 16'sd256,  16'sd100,  20'd500000},  1'b0, zero_res},
      '{'{1'b0, -16'sd2560, -16'sd8000, 20'd20000}, 1'b0, zero_res},
      '{'{1'b0, 16'sh7fff, 16'sd16384, 20'd1},      1'b0, zero_res},
      '{'{1'b1, 16'sd0,    16'sd0,    20'd0},       1'b1, ack_res},
      '{'{1'b0, 16'sd0,    16'sh8000, 20'hfffff},   1'b1, zero_res},
      '{'{1'b0, 16'sd5000, 16'sd25736, 20'd1000000}, 1'b0, zero_res},
      '{'{1'b0, 16'sd5000, 16'sd12868, 20'd250000},  1'b0, zero_res},
      '{'{1'b0, -16'sd100, -16'sd12868, 20'd999999}, 1'b0, zero_res}
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_sample(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

    // Default configuration, random traffic.
    repeat (170) send_sample(random_sample(1'b0, 1'b0), 1'b0, zero_res);

    // Smallest wheelbase and a zero threshold: the exact arc path for any turn.
    // Writes to the unused register indexes go in here as well.
    reconfigure(16'd1, 15'd0);
    for (int k = 1; k <= 3; k++) begin
      spare_idx = 3'(boi_pkg::CfgStartHeading) + 3'(k);
      write_reg(spare_idx, $urandom);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    repeat (170) send_sample(random_sample(1'b0, 1'b0), 1'b0, zero_res);

    // Largest wheelbase and threshold: midpoint integration almost everywhere. No idling.
    reconfigure(16'hffff, 15'h7fff);
    steady = 1'b1;
    repeat (170) send_sample(random_sample(1'b0, 1'b0), 1'b0, zero_res);
    steady = 1'b0;

    // Long straight runs forwards, then backwards, to saturate the position.
    reconfigure(16'd256, 15'd100);
    repeat (280) send_sample(random_sample(1'b1, 1'b0), 1'b0, zero_res);
    send_sample('{1'b1, 16'sd0, 16'sd0, 20'd0}, 1'b1, ack_res);
    repeat (280) send_sample(random_sample(1'b1, 1'b1), 1'b0, zero_res);

    // Random settings to finish.
    reconfigure(16'($urandom_range(1, 65535)), 15'($urandom));
    repeat (170) send_sample(random_sample(1'b0, 1'b0), 1'b0, zero_res);

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
